// ===== rtl/frml_pkg.sv =====
// Shared types, constants and back-end state codes for the frame rate meter and limiter.
package frml_pkg;

  localparam int TS_W         = 32;
  localparam int FPS_W        = 10;
  localparam int RATE_W       = 23;
  localparam int DELAY_W      = 10;
  localparam int WINDOW_DEF   = 20;
  localparam int MS_PER_S     = 1000;
  localparam int RATE_SCALE   = 256000;  // 1000 ms/s in Q.8

  localparam logic [FPS_W-1:0]  FPS_RESET    = FPS_W'(60);
  localparam logic [RATE_W-1:0] RATE_DEFAULT = RATE_W'(15360);  // 60.0 in Q.8
  localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};

  typedef struct packed {
    logic [TS_W-1:0] start_ms;
    logic [TS_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate_q8;
    logic [DELAY_W-1:0] delay_ms;
    logic [TS_W-1:0]    interval_ms;
  } out_t;

  // Word handed from the front to the back through the queue.
  typedef struct packed {
    logic [TS_W-1:0] interval;
    logic [TS_W-1:0] elapsed;
  } job_t;

  // Queue status/control seen by the back end.
  typedef struct packed {
    logic empty;
    logic pop;
  } qctl_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SUB,
    B_ADD,
    B_RATE_GO,
    B_RATE_WAIT,
    B_BUD_GO,
    B_BUD_WAIT,
    B_OUT
  } back_state_t;

endpackage

// ===== rtl/frml_front.sv =====
// Front end: takes input words, measures interval and elapsed time, pushes jobs.
module frml_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  frml_pkg::in_t in_data,
  input  logic          q_full,
  output logic          push,
  output frml_pkg::job_t job
);
  import frml_pkg::*;

  logic [TS_W-1:0] last_end_ms;
  logic            seen_first;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    job.interval = seen_first ? (in_data.now_ms - last_end_ms) : '0;
    job.elapsed  = in_data.now_ms - in_data.start_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first  <= 1'b0;
      last_end_ms <= '0;
    end else if (push) begin
      seen_first  <= 1'b1;
      last_end_ms <= in_data.now_ms;
    end
  end

endmodule

// ===== rtl/frml_queue.sv =====
// Two-entry job queue between front and back.
module frml_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  frml_pkg::job_t push_data,
  output logic           full,
  input  frml_pkg::qctl_t ctl_in,
  output logic           empty,
  output frml_pkg::job_t pop_data
);
  import frml_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop      = ctl_in.pop && !ctl_in.empty && (count != 2'd0);
  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/frml_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module frml_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 37
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic             ge;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] quo_next;

  always_comb begin
    shifted  = {rem, quo[NUM_W-1]};
    ge       = shifted >= {1'b0, den_r};
    rem_next = ge ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
    quo_next = {quo[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

endmodule

// ===== rtl/frml_back.sv =====
// Back end: interval ring, running sum, rate and budget divisions, result register.
module frml_back #(
  parameter int WINDOW = frml_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [frml_pkg::FPS_W-1:0] cfg_data,
  input  logic                       q_empty,
  input  frml_pkg::job_t             q_data,
  output frml_pkg::qctl_t            q_ctl,
  output logic                       out_valid,
  input  logic                       out_stall,
  output frml_pkg::out_t             out_data
);
  import frml_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = TS_W + CNT_W;
  localparam int NUM_W  = $clog2(RATE_SCALE * WINDOW + 1);
  localparam int QW     = (NUM_W > RATE_W) ? NUM_W : RATE_W;

  back_state_t state, state_next;

  logic [TS_W-1:0]    ring [WINDOW];
  logic [TS_W-1:0]    old;
  logic [TS_W-1:0]    intv;
  logic [TS_W-1:0]    elapsed;
  logic [SLOT_W-1:0]  slot;
  logic [CNT_W-1:0]   filled;
  logic [SUM_W-1:0]   sum;
  logic [RATE_W-1:0]  rate;
  logic [DELAY_W-1:0] budget;
  logic [FPS_W-1:0]   fps_limit;
  logic [FPS_W-1:0]   fps_eff;

  logic               pop;
  logic               full_ring;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_num;
  logic [SUM_W-1:0]   div_den;
  logic [NUM_W-1:0]   div_quo;
  logic               out_free;
  logic               load_out;
  logic [DELAY_W-1:0] delay;

  assign cfg_ready = 1'b1;
  assign full_ring = (filled == CNT_W'(WINDOW));
  assign fps_eff   = (fps_limit == '0) ? FPS_W'(1) : fps_limit;
  assign out_free  = !out_valid || !out_stall;
  assign q_ctl     = '{empty: q_empty, pop: pop};

  frml_div #(
    .NUM_W(NUM_W),
    .DEN_W(SUM_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:      if (!q_empty) state_next = B_SUB;
      B_SUB:       state_next = B_ADD;
      B_ADD:       state_next = B_RATE_GO;
      B_RATE_GO:   state_next = (sum == '0) ? B_BUD_GO : B_RATE_WAIT;
      B_RATE_WAIT: if (div_done) state_next = B_BUD_GO;
      B_BUD_GO:    state_next = B_BUD_WAIT;
      B_BUD_WAIT:  if (div_done) state_next = B_OUT;
      B_OUT:       if (out_free) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    div_num   = NUM_W'(RATE_SCALE * int'(filled));
    div_den   = sum;
    case (state)
      B_IDLE:    pop = !q_empty;
      B_RATE_GO: div_start = (sum != '0);
      B_BUD_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(MS_PER_S);
        div_den   = SUM_W'(fps_eff);
      end
      B_OUT:     load_out = out_free;
      default:   pop = 1'b0;
    endcase
  end

  assign delay = ({{(TS_W-DELAY_W){1'b0}}, budget} > elapsed) ?
                 (budget - elapsed[DELAY_W-1:0]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      slot      <= '0;
      filled    <= '0;
      sum       <= '0;
      fps_limit <= FPS_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) fps_limit <= cfg_data;
      if (state == B_SUB && full_ring) sum <= sum - SUM_W'(old);
      if (state == B_ADD) begin
        sum <= sum + SUM_W'(intv);
        if (!full_ring) filled <= filled + CNT_W'(1);
        slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
      end
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      intv    <= q_data.interval;
      elapsed <= q_data.elapsed;
    end
    if (state == B_RATE_GO && sum == '0) rate <= RATE_DEFAULT;
    if (state == B_RATE_WAIT && div_done) begin
      rate <= (QW'(div_quo) > QW'(RATE_MAX)) ? RATE_MAX : RATE_W'(div_quo);
    end
    if (state == B_BUD_WAIT && div_done) budget <= DELAY_W'(div_quo);
    if (load_out) begin
      out_data.rate_q8     <= rate;
      out_data.delay_ms    <= delay;
      out_data.interval_ms <= intv;
    end
  end

  // Interval ring
  always_ff @(posedge clk) begin
    if (pop) old <= ring[slot];
    if (state == B_ADD) ring[slot] <= intv;
  end

endmodule

// ===== rtl/frame_rate_meter_limiter.sv =====
// Top level of the frame rate meter and limiter.
//
// Each input word marks the end of a frame and carries the frame's start and
// end millisecond timestamps. For every word the block returns one output word:
// the interval since the previous frame end (0 for the first word), the
// average frame rate over the last WINDOW intervals as 1000*count/sum in
// unsigned Q.8 (60.0 when the sum is zero, saturated at the field's maximum),
// and the limiter delay, floor(1000/fps_limit) minus the frame's elapsed time,
// or 0 when that is not positive. A fps_limit of 0 is treated as 1.
// The front passes each accepted word into a two-entry queue; the back handles
// one word at a time, and its time per word is set by the single radix-2
// divider, which runs once for the rate (skipped when the window sum is zero)
// and once for the frame budget. The result register lets the back start the
// next word while a result is stalled.
// fps_limit is written through the cfg channel (always ready); write it only
// while no word is in flight. No clearing pass is needed after reset.
module frame_rate_meter_limiter #(
  parameter int WINDOW = frml_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [frml_pkg::FPS_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  frml_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output frml_pkg::out_t             out_data
);
  import frml_pkg::*;

  logic  push;
  job_t  push_job;
  logic  q_full;
  logic  q_empty;
  job_t  q_data;
  qctl_t q_ctl;

  // Front: interval and elapsed time from the timestamps
  frml_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .push    (push),
    .job     (push_job)
  );

  // Queue decouples the two halves
  frml_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_job),
    .full     (q_full),
    .ctl_in   (q_ctl),
    .empty    (q_empty),
    .pop_data (q_data)
  );

  // Back: ring, running sum, divisions, result register
  frml_back #(
    .WINDOW(WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_ctl    (q_ctl),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
